// File: sv/ookpw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ookpw_pkg
// Types, register indexes and reset constants of the OOK pulse-width sender.
// ----------------------------------------------------------------------------
package ookpw_pkg;

  localparam int CODE_W    = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_TICKS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_TICKS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_LINE  = 3'd4;

  // Register reset values
  localparam logic [7:0] RST_REPEAT_COUNT = 8'd15;
  localparam logic [7:0] RST_SHORT_TICKS  = 8'd1;
  localparam logic [7:0] RST_LONG_TICKS   = 8'd3;
  localparam logic [7:0] RST_SYNC_TICKS   = 8'd31;
  localparam logic       RST_INVERT_LINE  = 1'b0;

  // Input operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef struct packed {
    logic [7:0] repeat_count;
    logic [7:0] short_ticks;
    logic [7:0] long_ticks;
    logic [7:0] sync_ticks;
    logic       invert_line;
  } cfg_t;

  // Phase length with zero treated as one
  function automatic logic [7:0] eff_len(input logic [7:0] v);
    eff_len = (v == 8'd0) ? 8'd1 : v;
  endfunction

  // Phase length minus the tick spent switching into it
  function automatic logic [7:0] eff_len_m1(input logic [7:0] v);
    eff_len_m1 = (v == 8'd0) ? 8'd0 : v - 8'd1;
  endfunction

endpackage
`default_nettype wire

// File: sv/ookpw_tx.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ookpw_tx
// Transmit machine: sync symbol, code bits LSB first, repeats; one item per
// cycle, presenting the post-item carrier and running levels combinationally.
// ----------------------------------------------------------------------------
module ookpw_tx #(
  parameter int CODE_BITS = 24
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          step,
  input  wire                          op,
  input  wire [ookpw_pkg::CODE_W-1:0]  code,
  input  ookpw_pkg::cfg_t              cfg,
  output logic                         carrier_next,
  output logic                         running_next,
  output logic                         carrier,
  output logic                         running
);
  import ookpw_pkg::*;

  localparam int CNTW = $clog2(CODE_BITS + 1);
  localparam int SELW = $clog2(CODE_BITS);

  logic [CODE_BITS-1:0] code_word, code_word_next;
  logic [CNTW-1:0]      bit_index, bit_index_next;
  logic [7:0]           phase_rem, phase_rem_next;
  logic [7:0]           repeats_left, repeats_left_next;
  logic                 sync_pending, sync_pending_next;
  logic                 cur_bit;

  assign cur_bit = (bit_index < CNTW'(CODE_BITS)) ? code_word[bit_index[SELW-1:0]] : 1'b0;

  always_comb begin
    code_word_next    = code_word;
    bit_index_next    = bit_index;
    phase_rem_next    = phase_rem;
    repeats_left_next = repeats_left;
    sync_pending_next = sync_pending;
    carrier_next      = carrier;
    running_next      = running;
    if (step) begin
      if (op == OP_LOAD) begin
        code_word_next    = CODE_BITS'(code);
        sync_pending_next = 1'b1;
        carrier_next      = 1'b1;
        running_next      = 1'b1;
        bit_index_next    = '0;
        repeats_left_next = cfg.repeat_count;
        phase_rem_next    = eff_len(cfg.short_ticks);
      end else if (running) begin
        priority if (phase_rem != 8'd0) begin
          phase_rem_next = phase_rem - 8'd1;
        end else if (sync_pending) begin
          // sync high over: open the long sync gap
          carrier_next      = 1'b0;
          sync_pending_next = 1'b0;
          bit_index_next    = '0;
          phase_rem_next    = eff_len_m1(cfg.sync_ticks);
        end else if (carrier) begin
          // bit high over: low phase, then advance
          carrier_next   = 1'b0;
          phase_rem_next = cur_bit ? eff_len_m1(cfg.short_ticks)
                                   : eff_len_m1(cfg.long_ticks);
          bit_index_next = bit_index + CNTW'(1);
        end else if (bit_index < CNTW'(CODE_BITS)) begin
          carrier_next   = 1'b1;
          phase_rem_next = cur_bit ? eff_len_m1(cfg.long_ticks)
                                   : eff_len_m1(cfg.short_ticks);
        end else if (repeats_left != 8'd0) begin
          // word over: re-arm the sync
          repeats_left_next = repeats_left - 8'd1;
          sync_pending_next = 1'b1;
          carrier_next      = 1'b1;
          bit_index_next    = '0;
          phase_rem_next    = eff_len_m1(cfg.short_ticks);
        end else begin
          carrier_next   = 1'b0;
          running_next   = 1'b0;
          bit_index_next = '0;
          phase_rem_next = 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    code_word <= code_word_next;
    if (rst) begin
      bit_index    <= '0;
      phase_rem    <= 8'd0;
      repeats_left <= 8'd0;
      sync_pending <= 1'b0;
      carrier      <= 1'b0;
      running      <= 1'b0;
    end else begin
      bit_index    <= bit_index_next;
      phase_rem    <= phase_rem_next;
      repeats_left <= repeats_left_next;
      sync_pending <= sync_pending_next;
      carrier      <= carrier_next;
      running      <= running_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/ook_pulse_width_code_sender_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ook_pulse_width_code_sender_top
// OOK pulse-width code sender: sync plus code bits, repeated, on one line.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, op, code): a load starts or restarts a
//   burst with a new code, a tick advances the transmit machine one timer
//   tick. Each input transaction gives one result transaction (line,
//   busy_res): pin level and burst activity after that item.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): repeat
//   count, short, long and sync lengths, polarity. cfg_ready is always high;
//   write only while the block is idle.
// Timing: one item per clock cycle while in_stall is low; each result is registered into the output buffer.
// Stalling:
//   A two-entry output buffer holds results while out_stall is high; in_stall
//   rises only when both entries are full.
// Reset:
//   rst (synchronous) idles the transmit machine with the carrier off, empties
//   the output buffer and restores register defaults (15 repeats, short 1,
//   long 3, sync 31, no inversion).
// ----------------------------------------------------------------------------
module ook_pulse_width_code_sender_top #(
  parameter int CODE_BITS = 24
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire                            op,
  input  wire [ookpw_pkg::CODE_W-1:0]    code,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic                           line,
  output logic                           busy_res,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [ookpw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [ookpw_pkg::CFG_DAT_W-1:0] cfg_data
);
  import ookpw_pkg::*;

  cfg_t cfg;
  logic in_acc, out_acc, cfg_acc;
  logic carrier_next, running_next, carrier, running;
  logic [1:0] res_in;
  logic [1:0] slot0, slot1;
  logic [1:0] count;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_stall  = (count == 2'd2);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (count != 2'd0);
  assign out_acc   = out_valid && !out_stall;
  assign line      = slot0[1];
  assign busy_res  = slot0[0];
  assign res_in    = {carrier_next ^ cfg.invert_line, running_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.repeat_count <= RST_REPEAT_COUNT;
      cfg.short_ticks  <= RST_SHORT_TICKS;
      cfg.long_ticks   <= RST_LONG_TICKS;
      cfg.sync_ticks   <= RST_SYNC_TICKS;
      cfg.invert_line  <= RST_INVERT_LINE;
    end else if (cfg_acc) begin
      unique case (cfg_index)
        REG_REPEAT_COUNT: cfg.repeat_count <= cfg_data;
        REG_SHORT_TICKS:  cfg.short_ticks  <= cfg_data;
        REG_LONG_TICKS:   cfg.long_ticks   <= cfg_data;
        REG_SYNC_TICKS:   cfg.sync_ticks   <= cfg_data;
        REG_INVERT_LINE:  cfg.invert_line  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ookpw_tx #(
    .CODE_BITS(CODE_BITS)
  ) u_tx (
    .clk          (clk),
    .rst          (rst),
    .step         (in_acc),
    .op           (op),
    .code         (code),
    .cfg          (cfg),
    .carrier_next (carrier_next),
    .running_next (running_next),
    .carrier      (carrier),
    .running      (running)
  );

  // Output buffer: slot0 is the head, slot1 the overflow entry
  always_ff @(posedge clk) begin
    unique case (count)
      2'd0: begin
        if (in_acc) slot0 <= res_in;
      end
      2'd1: begin
        if (in_acc && out_acc) slot0 <= res_in;
        else if (in_acc)       slot1 <= res_in;
      end
      2'd2: begin
        if (out_acc) slot0 <= slot1;
      end
      default: ;
    endcase
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    in_acc && (op == OP_LOAD) |=> running && carrier)
    else $error("load did not start a burst");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !running |-> !carrier)
    else $error("carrier on while idle");

  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("output buffer overflow");

  a_drain_keeps: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2) && out_acc |=> out_valid && !in_stall)
    else $error("buffer lost an entry while draining");

endmodule
`default_nettype wire
